FILE: rtl/core/dwc_pkg.sv
// Shared types and constants of the depthwise 3x3 convolution block.
package dwc_pkg;

	localparam int DEF_WIDTH    = 32;
	localparam int DEF_HEIGHT   = 32;
	localparam int DEF_CHANNELS = 32;

	localparam int KTAPS  = 9;
	localparam int POS_W  = 5;
	localparam int SUM_W  = 35;
	localparam int SDATA_W = 32;
	localparam int MDATA_W = 56;

	// One result as it sits in the output queue.
	typedef struct packed {
		logic             last;
		logic [SUM_W-1:0] sum;
		logic [POS_W-1:0] col;
		logic [POS_W-1:0] row;
		logic [POS_W-1:0] chan;
	} res_t;

endpackage

FILE: rtl/core/depthwise_conv3x3_same.sv
// Top level of the depthwise 3x3 convolution block with zero padding.
//
// Depthwise 3x3 convolution, zero padding, same-size output. A transfer with
// s_tuser = 0 loads one signed kernel weight for a channel and tap (row*3+col);
// loads with an out-of-range channel or tap are dropped. A transfer with
// s_tuser = 1 delivers one pixel; pixels arrive in raster order, one whole
// channel plane after the other, and the block tracks the position itself.
// Each output leaves as soon as its neighborhood is complete: a pixel on the
// first row or in the first column releases nothing, any other pixel releases
// one result, two at the row end or on the last row, and four at the end of
// the last row; m_tlast marks the final result of a pixel. Sums
// are exact 35-bit two's complement. Rate: one transfer per cycle unless
// s_tready is low; a pixel that releases more than one result holds it low
// while the rest issue, as the single 3x3 window and nine multipliers serve
// one result per cycle. A 16-entry output queue absorbs stalls on m_tready;
// input is taken while results wait there if at most twelve are in flight.
// Line stores and weight store start undefined: no output may use a weight
// that was never loaded.
module depthwise_conv3x3_same #(
	parameter int WIDTH    = dwc_pkg::DEF_WIDTH,
	parameter int HEIGHT   = dwc_pkg::DEF_HEIGHT,
	parameter int CHANNELS = dwc_pkg::DEF_CHANNELS
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        s_tvalid,
	output logic                        s_tready,
	// chan_sel[4:0], tap[8:5], value[24:9], zero [31:25]
	input  logic [dwc_pkg::SDATA_W-1:0] s_tdata,
	// func: 0 weight load, 1 pixel
	input  logic                        s_tuser,
	output logic                        m_tvalid,
	input  logic                        m_tready,
	// out_chan[4:0], out_row[9:5], out_col[14:10], sum[49:15], zero [55:50]
	output logic [dwc_pkg::MDATA_W-1:0] m_tdata,
	output logic                        m_tlast
);
	import dwc_pkg::*;

	localparam int CW  = (WIDTH > 1) ? $clog2(WIDTH) : 1;
	localparam int RW  = (HEIGHT > 1) ? $clog2(HEIGHT) : 1;
	localparam int CHW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
	localparam int FDEPTH = 16;
	localparam int FAW    = 4;
	localparam int CREDIT_MAX = FDEPTH - 4;

	// Result kinds released by one pixel, in order of emission.
	typedef enum logic [1:0] {
		K_PREV      = 2'd0,   // (r-1, c-1)
		K_PREV_EDGE = 2'd1,   // (r-1, WIDTH-1)
		K_LAST      = 2'd2,   // (r, c-1) on the last row
		K_LAST_EDGE = 2'd3    // (r, WIDTH-1) on the last row
	} kind_t;

	// Input fields
	logic [4:0]         chan_sel;
	logic [3:0]         tap;
	logic signed [15:0] value;
	assign chan_sel = s_tdata[4:0];
	assign tap      = s_tdata[8:5];
	assign value    = s_tdata[24:9];

	logic accept, pix_acc, wt_acc, wt_ok;
	assign accept  = s_tvalid && s_tready;
	assign pix_acc = accept && s_tuser;
	assign wt_acc  = accept && !s_tuser;

	// Position counters
	logic [CW-1:0]  col_q;
	logic [RW-1:0]  row_q;
	logic [CHW-1:0] chan_q;
	logic col_last, row_last, chan_last;
	assign col_last  = (col_q == CW'(WIDTH - 1));
	assign row_last  = (row_q == RW'(HEIGHT - 1));
	assign chan_last = (chan_q == CHW'(CHANNELS - 1));

	// Which results this pixel releases, and how many
	logic [3:0] kinds_acc;
	logic [2:0] n_acc;
	assign kinds_acc[0] = (row_q != '0) && (col_q != '0);
	assign kinds_acc[1] = (row_q != '0) && col_last;
	assign kinds_acc[2] = row_last && (col_q != '0);
	assign kinds_acc[3] = row_last && col_last;
	assign n_acc = {2'b0, kinds_acc[0]} + {2'b0, kinds_acc[1]}
		+ {2'b0, kinds_acc[2]} + {2'b0, kinds_acc[3]};

	// Flow control: block_q holds input off while one pixel's results share the
	// window; credit_q counts results from transfer until they leave the queue.
	logic [1:0]   block_q;
	logic [FAW:0] credit_q;
	logic         pop;
	assign s_tready = (block_q == 2'd0) && (credit_q <= (FAW+1)'(CREDIT_MAX));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q    <= '0;
			row_q    <= '0;
			chan_q   <= '0;
			block_q  <= 2'd0;
			credit_q <= '0;
		end else begin
			if (pix_acc) begin
				if (col_last) begin
					col_q <= '0;
					if (row_last) begin
						row_q  <= '0;
						chan_q <= chan_last ? '0 : chan_q + 1'b1;
					end else begin
						row_q <= row_q + 1'b1;
					end
				end else begin
					col_q <= col_q + 1'b1;
				end
			end
			if (pix_acc && (n_acc != 3'd0)) begin
				block_q <= 2'(n_acc - 3'd1);
			end else if (block_q != 2'd0) begin
				block_q <= block_q - 2'd1;
			end
			credit_q <= credit_q + (pix_acc ? (FAW+1)'(n_acc) : '0)
				- (pop ? (FAW+1)'(1) : '0);
		end
	end

	// Weight store: a row of nine taps per channel, written one tap per transfer
	logic [CHW+4:0] ch_ext;
	logic [CHW-1:0] wch;
	assign ch_ext = {{CHW{1'b0}}, chan_sel};
	assign wch    = ch_ext[CHW-1:0];
	assign wt_ok  = wt_acc && (ch_ext < (CHW+5)'(CHANNELS)) && (tap < 4'(KTAPS));

	logic signed [15:0] wmem   [CHANNELS][KTAPS];
	logic signed [15:0] wrow_q [KTAPS];

	// Stage 1: pixel captured with its line store read
	logic               pv_s1;
	logic signed [15:0] v_s1;
	logic [CW-1:0]      c_s1;
	logic [RW-1:0]      r_s1;
	logic [CHW-1:0]     ch_s1;
	logic [3:0]         kinds_s1;
	logic [31:0]        rd_s1;    // [31:16] row r-1, [15:0] row r-2

	logic [31:0] lmem [WIDTH];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pv_s1 <= 1'b0;
		end else begin
			pv_s1 <= pix_acc;
		end
	end

	always_ff @(posedge clk) begin
		if (pix_acc) begin
			v_s1     <= value;
			c_s1     <= col_q;
			r_s1     <= row_q;
			ch_s1    <= chan_q;
			kinds_s1 <= kinds_acc;
		end
	end

	// Line store: read at transfer, write back the shifted pair in the cycle after.
	// With WIDTH above 1, consecutive pixels never share a column, so read and write never collide.
	always_ff @(posedge clk) begin
		if (pix_acc) begin
			rd_s1 <= lmem[col_q];
		end
		if (pv_s1) begin
			lmem[c_s1] <= {v_s1, rd_s1[31:16]};
		end
	end

	always_ff @(posedge clk) begin
		if (wt_ok) begin
			wmem[wch][tap] <= value;
		end
		if (pv_s1) begin
			wrow_q <= wmem[ch_s1];
		end
	end

	// 3x3 window, bottom-right cell holds the newest pixel
	logic signed [15:0] win_q [3][3];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 3; i++) begin
				for (int j = 0; j < 3; j++) begin
					win_q[i][j] <= '0;
				end
			end
		end else if (pv_s1) begin
			for (int i = 0; i < 3; i++) begin
				win_q[i][0] <= win_q[i][1];
				win_q[i][1] <= win_q[i][2];
			end
			win_q[0][2] <= rd_s1[15:0];
			win_q[1][2] <= rd_s1[31:16];
			win_q[2][2] <= v_s1;
		end
	end

	// Result sequencer: issue one pending kind per cycle, lowest first
	logic [3:0]     kinds_q;
	logic [CW-1:0]  sc_q;
	logic [RW-1:0]  sr_q;
	logic [CHW-1:0] sch_q;
	logic           iss_v, iss_last;
	logic [3:0]     kinds_left;
	kind_t          kind;

	always_comb begin
		kind       = K_PREV;
		kinds_left = kinds_q;
		if (kinds_q[0]) begin
			kind          = K_PREV;
			kinds_left[0] = 1'b0;
		end else if (kinds_q[1]) begin
			kind          = K_PREV_EDGE;
			kinds_left[1] = 1'b0;
		end else if (kinds_q[2]) begin
			kind          = K_LAST;
			kinds_left[2] = 1'b0;
		end else begin
			kind          = K_LAST_EDGE;
			kinds_left[3] = 1'b0;
		end
	end
	assign iss_v    = (kinds_q != 4'd0);
	assign iss_last = (kinds_left == 4'd0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kinds_q <= 4'd0;
		end else if (pv_s1) begin
			kinds_q <= kinds_s1;
		end else if (iss_v) begin
			kinds_q <= kinds_left;
		end
	end

	always_ff @(posedge clk) begin
		if (pv_s1) begin
			sc_q  <= c_s1;
			sr_q  <= r_s1;
			sch_q <= ch_s1;
		end
	end

	// Pick window cells for the issued kind; drop taps that fall off the image
	logic signed [15:0] a_op [KTAPS];
	logic top_edge, left_edge;
	assign top_edge  = (sr_q == RW'(1));
	assign left_edge = (sc_q == CW'(1));

	for (genvar gm = 0; gm < 3; gm++) begin : g_row
		for (genvar gn = 0; gn < 3; gn++) begin : g_col
			localparam int MD = (gm < 2) ? gm + 1 : gm;
			localparam int ND = (gn < 2) ? gn + 1 : gn;
			always_comb begin
				case (kind)
					K_PREV:
						a_op[gm*3+gn] = ((top_edge && gm == 0) || (left_edge && gn == 0))
							? 16'sd0 : win_q[gm][gn];
					K_PREV_EDGE:
						a_op[gm*3+gn] = ((top_edge && gm == 0) || gn == 2)
							? 16'sd0 : win_q[gm][ND];
					K_LAST:
						a_op[gm*3+gn] = (gm == 2 || (left_edge && gn == 0))
							? 16'sd0 : win_q[MD][gn];
					default:
						a_op[gm*3+gn] = (gm == 2 || gn == 2) ? 16'sd0 : win_q[MD][ND];
				endcase
			end
		end
	end

	// Output coordinates, low five bits of the position
	logic [RW-1:0]  orow;
	logic [CW-1:0]  ocol;
	logic [RW+4:0]  orow_ext;
	logic [CW+4:0]  ocol_ext;
	logic [CHW+4:0] och_ext;
	assign orow     = (kind == K_LAST || kind == K_LAST_EDGE) ? sr_q : sr_q - 1'b1;
	assign ocol     = (kind == K_PREV_EDGE || kind == K_LAST_EDGE) ? sc_q : sc_q - 1'b1;
	assign orow_ext = {5'b0, orow};
	assign ocol_ext = {5'b0, ocol};
	assign och_ext  = {5'b0, sch_q};

	// Stage 2: nine products
	logic               v_s2, last_s2;
	logic [POS_W-1:0]   chan_s2, row_s2, col_s2;
	logic signed [31:0] prod_s2 [KTAPS];

	// Stage 3: three partial sums
	logic               v_s3, last_s3;
	logic [POS_W-1:0]   chan_s3, row_s3, col_s3;
	logic signed [33:0] part_s3 [3];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			v_s2 <= iss_v;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		for (int t = 0; t < KTAPS; t++) begin
			prod_s2[t] <= a_op[t] * wrow_q[t];
		end
		last_s2 <= iss_last;
		chan_s2 <= och_ext[4:0];
		row_s2  <= orow_ext[4:0];
		col_s2  <= ocol_ext[4:0];
		for (int i = 0; i < 3; i++) begin
			part_s3[i] <= 34'(prod_s2[3*i]) + 34'(prod_s2[3*i+1]) + 34'(prod_s2[3*i+2]);
		end
		last_s3 <= last_s2;
		chan_s3 <= chan_s2;
		row_s3  <= row_s2;
		col_s3  <= col_s2;
	end

	// Output queue: final add on the way in
	res_t          fifo_q [FDEPTH];
	res_t          head;
	logic [FAW-1:0] wr_ptr_q, rd_ptr_q;
	logic [FAW:0]   count_q;
	res_t          push_res;

	always_comb begin
		push_res.last = last_s3;
		push_res.sum  = 35'(part_s3[0]) + 35'(part_s3[1]) + 35'(part_s3[2]);
		push_res.col  = col_s3;
		push_res.row  = row_s3;
		push_res.chan = chan_s3;
	end

	always_ff @(posedge clk) begin
		if (v_s3) begin
			fifo_q[wr_ptr_q] <= push_res;
		end
	end

	assign pop = m_tvalid && m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (v_s3) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			count_q <= count_q + (v_s3 ? (FAW+1)'(1) : '0) - (pop ? (FAW+1)'(1) : '0);
		end
	end

	assign head     = fifo_q[rd_ptr_q];
	assign m_tvalid = (count_q != '0);
	assign m_tdata  = {6'b0, head.sum, head.col, head.row, head.chan};
	assign m_tlast  = head.last;

endmodule

FILE: rtl/core/dwc_checker.sv
// Port-level assertions for the depthwise 3x3 convolution block, with bind.
module dwc_checker #(
	parameter int WIDTH    = dwc_pkg::DEF_WIDTH,
	parameter int HEIGHT   = dwc_pkg::DEF_HEIGHT,
	parameter int CHANNELS = dwc_pkg::DEF_CHANNELS
) (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        m_tvalid,
	input logic                        m_tready,
	input logic [dwc_pkg::MDATA_W-1:0] m_tdata,
	input logic                        m_tlast
);
	import dwc_pkg::*;

	localparam logic [4:0] COL_PEN  = 5'(WIDTH - 2);
	localparam logic [4:0] ROW_PEN  = 5'(HEIGHT - 2);
	localparam logic [4:0] CHAN_TOP = 5'(CHANNELS - 1);

	// Hold a stalled result
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
		else $error("stalled result changed");

	// A result that is not last must sit in the next-to-last column or row, where its row-end or last-row partner follows
	a_burst: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tlast |->
			(m_tdata[14:10] == COL_PEN) || (m_tdata[9:5] == ROW_PEN))
		else $error("non-final result at an unexpected position");

	// Keep padding bits zero
	a_pad: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[MDATA_W-1:POS_W*3+SUM_W] == '0))
		else $error("padding bits set");

	// Channel stays inside the plane count when it fits five bits
	a_chan: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (CHANNELS <= 32) |-> (m_tdata[4:0] <= CHAN_TOP))
		else $error("channel out of range");

endmodule

bind depthwise_conv3x3_same dwc_checker #(
	.WIDTH(WIDTH),
	.HEIGHT(HEIGHT),
	.CHANNELS(CHANNELS)
) u_dwc_checker (
	.clk(clk),
	.arst_n(arst_n),
	.m_tvalid(m_tvalid),
	.m_tready(m_tready),
	.m_tdata(m_tdata),
	.m_tlast(m_tlast)
);
